[rtl/core/bdy_pkg.sv]
// ============================================================================
// bdy_pkg
// Shared types and codes for the binary buddy allocator.
// ============================================================================
package bdy_pkg;

    typedef enum logic [0:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } bdy_cmd_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_SPACE  = 2'd1,
        STAT_BAD_ORDER = 2'd2
    } bdy_stat_t;

    typedef enum logic [3:0] {
        ST_CLEAR,   // post-reset sweep of the buddy memory
        ST_IDLE,
        ST_ALLOC,   // range check, free-list search, issue pop read
        ST_POP,     // unlink list head
        ST_A_TRD,   // buddy toggle read (allocate)
        ST_A_TWR,   // buddy toggle write (allocate)
        ST_PUSH,    // push block on a free list
        ST_PUSH2,   // fix back link of old head
        ST_FREE,    // range check, block number
        ST_F_TRD,   // buddy toggle read (free)
        ST_F_TWR,   // buddy toggle write (free)
        ST_F_RRD,   // read links of the buddy
        ST_F_RWR,   // unlink buddy, climb one order
        ST_DONE     // hand result to the output register
    } bdy_state_t;

    localparam int OFFSET_W = 16;
    localparam int ORDER_W  = 6;

endpackage

[rtl/core/buddy_allocator_unit.sv]
// ============================================================================
// buddy_allocator_unit
// Binary buddy allocator over a 2^REGION_ORDER byte region.
// ============================================================================
// One command at a time. Buddy bits and the next/prev links of the per-order
// free lists sit in single-port-read synchronous memories; the sequencer reads
// one entry, then writes it back in the following cycle. An allocate checks
// the order and searches the free lists, pops the list head, toggles the buddy
// bit when the block comes from a lower list, and per split level pushes the
// upper half, fixes the back link of the old head when that list was not empty
// and toggles the buddy bit. A free checks the order, then per coalesced level
// toggles the buddy bit and reads and unlinks the buddy, toggles once more
// unless it climbs to the region order, pushes the block, fixing the old
// head's back link when that list was not empty, and hands the result off.
// A bad order or an empty search goes straight to the hand-off. The unit
// returns to idle between commands. The result goes to an output register,
// so the next command is taken while a result still waits. After reset the
// buddy memory is swept clear, one entry per cycle, with in_stall high.
// ============================================================================
module buddy_allocator_unit
    import bdy_pkg::*;
#(
    parameter int MIN_ORDER    = 5,
    parameter int MAX_ORDER    = 16,
    parameter int REGION_ORDER = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                command,
    input  logic [ORDER_W-1:0]  block_order,
    input  logic [OFFSET_W-1:0] free_offset,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [OFFSET_W-1:0] granted_offset
);

    // block numbers: BW bits; links carry one more bit, top bit set means NIL
    localparam int BW     = REGION_ORDER - MIN_ORDER;
    localparam int LNW    = BW + 1;
    localparam int NBLK   = 1 << BW;
    localparam int NPAIRS = NBLK - 1;
    localparam int NORD   = MAX_ORDER - MIN_ORDER + 1;
    localparam int TOPL   = ((REGION_ORDER > MAX_ORDER) ? REGION_ORDER : MAX_ORDER)
                            - MIN_ORDER;
    localparam int LW     = $clog2(TOPL + 2);
    localparam int HW     = (NORD > 1) ? $clog2(NORD) : 1;
    localparam bit REG_FITS = (REGION_ORDER <= MAX_ORDER);

    localparam logic [LNW-1:0]     NIL      = {1'b1, {BW{1'b0}}};
    localparam logic [LW-1:0]      LV_REG   = LW'(REGION_ORDER - MIN_ORDER);
    localparam logic [LW-1:0]      LV_NORD  = LW'(NORD);
    localparam logic [ORDER_W-1:0] ORD_MIN  = ORDER_W'(MIN_ORDER);
    localparam logic [ORDER_W-1:0] ORD_MAX  = ORDER_W'(MAX_ORDER);
    localparam logic [ORDER_W-1:0] ORD_REG  = ORDER_W'(REGION_ORDER);
    localparam logic [BW-1:0]      CLR_LAST = BW'(NPAIRS - 1);

    // pair index of block blk at relative order lvl
    function automatic logic [BW-1:0] pair_slot(input logic [LW-1:0] lvl,
                                                input logic [BW-1:0] blk);
        logic [BW:0] full;
        logic [BW:0] base;
        full = {1'b1, {BW{1'b0}}};
        base = full - (full >> lvl) + ((BW+1)'(blk) >> (lvl + LW'(1)));
        return base[BW-1:0];
    endfunction

    // ---------------------------------------------------------------- memories
    logic             bud_mem [NPAIRS];
    logic [LNW-1:0]   nxt_mem [NBLK];
    logic [LNW-1:0]   prv_mem [NBLK];

    logic             bud_we, bud_wd, bud_rd_reg;
    logic [BW-1:0]    bud_wa, bud_ra;
    logic             nxt_we, prv_we;
    logic [BW-1:0]    nxt_wa, nxt_ra, prv_wa, prv_ra;
    logic [LNW-1:0]   nxt_wd, prv_wd, nxt_rd_reg, prv_rd_reg;

    always_ff @(posedge clk)
    begin
        if (bud_we)
        begin
            bud_mem[bud_wa] <= bud_wd;
        end
        bud_rd_reg <= bud_mem[bud_ra];
    end

    always_ff @(posedge clk)
    begin
        if (nxt_we)
        begin
            nxt_mem[nxt_wa] <= nxt_wd;
        end
        nxt_rd_reg <= nxt_mem[nxt_ra];
    end

    always_ff @(posedge clk)
    begin
        if (prv_we)
        begin
            prv_mem[prv_wa] <= prv_wd;
        end
        prv_rd_reg <= prv_mem[prv_ra];
    end

    // ---------------------------------------------------------------- control
    bdy_state_t           state_reg, state_next;
    logic                 cmd_reg, cmd_next;
    logic [ORDER_W-1:0]   ord_reg, ord_next;
    logic [OFFSET_W-1:0]  off_reg, off_next;
    logic [LW-1:0]        lvl_reg, lvl_next;
    logic [LW-1:0]        tgt_reg, tgt_next;
    logic [BW-1:0]        blk_reg, blk_next;
    logic [BW-1:0]        pb_reg, pb_next;
    logic [LNW-1:0]       hold_reg, hold_next;
    logic [1:0]           stat_reg, stat_next;
    logic [BW-1:0]        clr_reg, clr_next;
    logic [LNW-1:0]       heads_reg [NORD];

    logic                 head_we;
    logic [HW-1:0]        head_wi;
    logic [LNW-1:0]       head_wd;

    logic                 out_valid_reg;
    logic [1:0]           out_status_reg;
    logic [OFFSET_W-1:0]  out_granted_reg;
    logic                 out_load;

    // free-list search helpers
    logic [LW-1:0]        lvl_req;
    logic [LW-1:0]        found;
    logic                 got;
    logic [BW-1:0]        lvl_bit;
    logic [BW-1:0]        bud_blk;
    logic [REGION_ORDER-1:0] byte_addr;

    assign lvl_bit   = BW'(1) << lvl_reg;
    assign bud_blk   = blk_reg ^ lvl_bit;
    assign byte_addr = REGION_ORDER'(blk_reg) << MIN_ORDER;

    always_comb
    begin
        lvl_req = (ord_reg < ORD_MIN) ? '0 : LW'(ord_reg - ORD_MIN);
        found   = '0;
        got     = 1'b0;
        for (int i = NORD - 1; i >= 0; i--)
        begin
            if (!heads_reg[i][BW] && (LW'(i) >= lvl_req))
            begin
                found = LW'(i);
                got   = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        ord_next   = ord_reg;
        off_next   = off_reg;
        lvl_next   = lvl_reg;
        tgt_next   = tgt_reg;
        blk_next   = blk_reg;
        pb_next    = pb_reg;
        hold_next  = hold_reg;
        stat_next  = stat_reg;
        clr_next   = clr_reg;
        head_we    = 1'b0;
        head_wi    = HW'(lvl_reg);
        head_wd    = NIL;
        bud_we     = 1'b0;
        bud_wa     = pair_slot(lvl_reg, blk_reg);
        bud_wd     = 1'b0;
        bud_ra     = pair_slot(lvl_reg, blk_reg);
        nxt_we     = 1'b0;
        nxt_wa     = pb_reg;
        nxt_wd     = NIL;
        nxt_ra     = bud_blk;
        prv_we     = 1'b0;
        prv_wa     = pb_reg;
        prv_wd     = NIL;
        prv_ra     = bud_blk;
        out_load   = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                bud_we   = 1'b1;
                bud_wa   = clr_reg;
                bud_wd   = 1'b0;
                // initial free list holds block 0 alone
                if (REG_FITS && clr_reg == '0)
                begin
                    nxt_we = 1'b1;
                    nxt_wa = '0;
                    prv_we = 1'b1;
                    prv_wa = '0;
                end
                clr_next = clr_reg + BW'(1);
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = command;
                    ord_next   = block_order;
                    off_next   = free_offset;
                    state_next = (command == CMD_FREE) ? ST_FREE : ST_ALLOC;
                end
            end

            ST_ALLOC:
            begin
                if (ord_reg > ORD_MAX)
                begin
                    stat_next  = STAT_BAD_ORDER;
                    state_next = ST_DONE;
                end
                else if (!got)
                begin
                    stat_next  = STAT_NO_SPACE;
                    state_next = ST_DONE;
                end
                else
                begin
                    blk_next   = heads_reg[HW'(found)][BW-1:0];
                    nxt_ra     = heads_reg[HW'(found)][BW-1:0];
                    lvl_next   = found;
                    tgt_next   = lvl_req;
                    state_next = ST_POP;
                end
            end

            ST_POP:
            begin
                head_we = 1'b1;
                head_wd = nxt_rd_reg;
                if (!nxt_rd_reg[BW])
                begin
                    prv_we = 1'b1;
                    prv_wa = nxt_rd_reg[BW-1:0];
                    prv_wd = NIL;
                end
                if (lvl_reg < LV_REG)
                begin
                    state_next = ST_A_TRD;
                end
                else if (lvl_reg > tgt_reg)
                begin
                    lvl_next   = lvl_reg - LW'(1);
                    pb_next    = blk_reg + (BW'(1) << (lvl_reg - LW'(1)));
                    state_next = ST_PUSH;
                end
                else
                begin
                    stat_next  = STAT_OK;
                    state_next = ST_DONE;
                end
            end

            ST_A_TRD:
            begin
                state_next = ST_A_TWR;
            end

            ST_A_TWR:
            begin
                bud_we = 1'b1;
                bud_wd = ~bud_rd_reg;
                if (lvl_reg > tgt_reg)
                begin
                    // split: upper half goes on the next list down
                    lvl_next   = lvl_reg - LW'(1);
                    pb_next    = blk_reg + (BW'(1) << (lvl_reg - LW'(1)));
                    state_next = ST_PUSH;
                end
                else
                begin
                    stat_next  = STAT_OK;
                    state_next = ST_DONE;
                end
            end

            ST_PUSH:
            begin
                if (lvl_reg < LV_NORD)
                begin
                    hold_next = heads_reg[head_wi];
                    nxt_we    = 1'b1;
                    nxt_wd    = heads_reg[head_wi];
                    prv_we    = 1'b1;
                    head_we   = 1'b1;
                    head_wd   = {1'b0, pb_reg};
                end
                if (lvl_reg < LV_NORD && !heads_reg[head_wi][BW])
                begin
                    state_next = ST_PUSH2;
                end
                else if (cmd_reg == CMD_ALLOC)
                begin
                    state_next = ST_A_TRD;
                end
                else
                begin
                    stat_next  = STAT_OK;
                    state_next = ST_DONE;
                end
            end

            ST_PUSH2:
            begin
                prv_we = 1'b1;
                prv_wa = hold_reg[BW-1:0];
                prv_wd = {1'b0, pb_reg};
                if (cmd_reg == CMD_ALLOC)
                begin
                    state_next = ST_A_TRD;
                end
                else
                begin
                    stat_next  = STAT_OK;
                    state_next = ST_DONE;
                end
            end

            ST_FREE:
            begin
                if (ord_reg < ORD_MIN || ord_reg > ORD_MAX || ord_reg > ORD_REG)
                begin
                    stat_next  = STAT_BAD_ORDER;
                    state_next = ST_DONE;
                end
                else
                begin
                    lvl_next = LW'(ord_reg - ORD_MIN);
                    blk_next = BW'(off_reg >> MIN_ORDER)
                               & ~((BW'(1) << LW'(ord_reg - ORD_MIN)) - BW'(1));
                    pb_next  = blk_next;
                    state_next = (ord_reg == ORD_REG) ? ST_PUSH : ST_F_TRD;
                end
            end

            ST_F_TRD:
            begin
                state_next = ST_F_TWR;
            end

            ST_F_TWR:
            begin
                bud_we = 1'b1;
                bud_wd = ~bud_rd_reg;
                if (!bud_rd_reg)
                begin
                    // buddy still in use: park this block
                    pb_next    = blk_reg;
                    state_next = ST_PUSH;
                end
                else
                begin
                    state_next = ST_F_RRD;
                end
            end

            ST_F_RRD:
            begin
                state_next = ST_F_RWR;
            end

            ST_F_RWR:
            begin
                if (lvl_reg < LV_NORD)
                begin
                    if (prv_rd_reg[BW])
                    begin
                        head_we = 1'b1;
                        head_wd = nxt_rd_reg;
                    end
                    else
                    begin
                        nxt_we = 1'b1;
                        nxt_wa = prv_rd_reg[BW-1:0];
                        nxt_wd = nxt_rd_reg;
                    end
                    if (!nxt_rd_reg[BW])
                    begin
                        prv_we = 1'b1;
                        prv_wa = nxt_rd_reg[BW-1:0];
                        prv_wd = prv_rd_reg;
                    end
                end
                blk_next = blk_reg & ~lvl_bit;
                pb_next  = blk_reg & ~lvl_bit;
                lvl_next = lvl_reg + LW'(1);
                state_next = (lvl_reg + LW'(1) == LV_REG) ? ST_PUSH : ST_F_TRD;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            for (int i = 0; i < NORD; i++)
            begin
                heads_reg[i] <= (REG_FITS && i == REGION_ORDER - MIN_ORDER) ? '0 : NIL;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (head_we)
            begin
                heads_reg[head_wi] <= head_wd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        ord_reg  <= ord_next;
        off_reg  <= off_next;
        lvl_reg  <= lvl_next;
        tgt_reg  <= tgt_next;
        blk_reg  <= blk_next;
        pb_reg   <= pb_next;
        hold_reg <= hold_next;
        stat_reg <= stat_next;
    end

    // output register: one transfer waits here while the next command runs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg  <= stat_reg;
            out_granted_reg <= (stat_reg == STAT_OK && cmd_reg == CMD_ALLOC)
                               ? OFFSET_W'(byte_addr) : '0;
        end
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign granted_offset = out_granted_reg;

endmodule

[rtl/core/bdy_checker.sv]
// ============================================================================
// bdy_checker
// Port-level checks on the allocator's result channel.
// ============================================================================
module bdy_checker
    import bdy_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input logic [1:0]          status,
    input logic [OFFSET_W-1:0] granted_offset
);

    // only three result codes exist
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STAT_OK || status == STAT_NO_SPACE ||
                       status == STAT_BAD_ORDER))
        else $error("illegal status code");

    // failed commands carry no offset
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STAT_OK) |-> (granted_offset == '0))
        else $error("offset on failed command");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status) &&
                                      $stable(granted_offset)))
        else $error("stalled result changed");

endmodule

bind buddy_allocator_unit bdy_checker u_bdy_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .granted_offset (granted_offset)
);
